@@ rtl/core/chmsh_pkg.sv @@
// chmsh_pkg: shared constants, types and arithmetic helpers of the chebyshev moment shift block
// depends on nothing; every rtl/core module references it by scoped names
`default_nettype none
package chmsh_pkg;

   localparam int MAX_ORDER  = 8;
   localparam int COMPONENTS = 9;

   localparam int ORDER_W   = 4;
   localparam int SCALE_W   = 31;
   localparam int INDEX_W   = 13;
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DW    = 32;

   localparam int N_W      = $clog2(MAX_ORDER + 1);
   localparam int IDX_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int COMP_W   = $clog2(COMPONENTS);
   localparam int WT_DEPTH = 2 * MAX_ORDER * MAX_ORDER;
   localparam int WT_AW    = $clog2(WT_DEPTH);
   localparam int CO_DEPTH = COMPONENTS * MAX_ORDER * MAX_ORDER * MAX_ORDER;
   localparam int CO_AW    = $clog2(CO_DEPTH);
   localparam int LIM_W    = INDEX_W + 1;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int ACC_W    = PROD_W + $clog2(MAX_ORDER) + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int DRAIN_CYCLES = 6;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(134217728);

   localparam logic [CSR_IDX_W-1:0] CSR_ORDER = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      CMD_LOAD_WEIGHT = 2'd0,
      CMD_LOAD_CHILD  = 2'd1,
      CMD_COMPUTE     = 2'd2,
      CMD_READ        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      PASS_Z,
      PASS_Y,
      PASS_X
   } pass_type;

   // h[0] for the z pass, h[1] for y, h[2] for x
   typedef struct packed {
      cmd_type                   cmd;
      logic [INDEX_W-1:0]        index;
      logic signed [DATA_W-1:0]  value;
      logic [2:0]                h;
      logic                      reject;
      logic                      noop;
   } job_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      pass_type         pass;
      logic [CO_AW-1:0] dst;
   } pipe_type;

   typedef struct packed {
      logic busy;
   } bk_status_type;

   function automatic logic [CO_AW-1:0] flat_addr(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b,
                                                  input logic [IDX_W-1:0] c,
                                                  input logic [COMP_W-1:0] d,
                                                  input logic [N_W-1:0] n);
      logic [CO_AW-1:0] t;
      t = CO_AW'(a) * CO_AW'(n) + CO_AW'(b);
      t = t * CO_AW'(n) + CO_AW'(c);
      t = t * CO_AW'(COMPONENTS) + CO_AW'(d);
      return t;
   endfunction

   // shift right by 30 with round half up, then saturate to 32 bits
   function automatic logic signed [DATA_W-1:0] sat_round30(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      logic [ACC_W-31:0]       r;
      logic                    in_range;
      t = a + (ACC_W'(1) << 29);
      r = t[ACC_W-1:30];
      in_range = (&r[ACC_W-31:DATA_W-1]) || !(|r[ACC_W-31:DATA_W-1]);
      if (in_range) begin
         return r[DATA_W-1:0];
      end else if (r[ACC_W-31]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/chebyshev_moment_shift_top.sv @@
// chebyshev_moment_shift_top: m2m shift of a chebyshev tensor interpolation
// depends on chmsh_pkg, chmsh_front, chmsh_queue, chmsh_back
//
// usage: both item channels look like queues. push an item with req_push while req_full
// is low; take a result with rsp_pop while rsp_empty is low. every item gives one result.
// the csr channel (csr_valid/csr_ready, always ready) writes order (index 0) and
// scale (index 1); write it only while the block is idle.
// cmd 0 loads a weight, cmd 1 a child coefficient, cmd 3 reads a parent coefficient,
// cmd 2 runs the shift over the child store into the parent store.
// a load result passes through the queue entry and the result register; a read also
// passes through the registered store read port. an item is taken only while the back
// is idle and the single result register is empty, so no new item starts while a
// result waits.
// compute runs three passes on one multiply-accumulate pipeline, one product per
// cycle; each pass issues 9*n^4 products and then drains the pipeline, and the
// result shows once the x pass has drained.
// two input items queue between front and back, so the input keeps taking items
// while a result waits; when the receiver stalls the queue fills and req_full rises.
// reset clears control state only; store contents stay undefined until written.
`default_nettype none
module chebyshev_moment_shift_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [1:0]                            req_cmd,
   input  logic [chmsh_pkg::INDEX_W-1:0]         req_index,
   input  logic signed [chmsh_pkg::DATA_W-1:0]   req_value,
   input  logic                                  req_neg_x,
   input  logic                                  req_neg_y,
   input  logic                                  req_neg_z,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [chmsh_pkg::DATA_W-1:0]   rsp_data,
   output logic                                  rsp_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [chmsh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [chmsh_pkg::CSR_DW-1:0]          csr_wdata
);

   logic [chmsh_pkg::ORDER_W-1:0] order_ff;
   logic [chmsh_pkg::SCALE_W-1:0] scale_ff;
   logic [chmsh_pkg::N_W-1:0]     n;
   chmsh_pkg::job_type            front_job, head_job;
   logic                          q_empty, job_pop;
   chmsh_pkg::bk_status_type      bk_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= chmsh_pkg::ORDER_RESET;
         scale_ff <= chmsh_pkg::SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            chmsh_pkg::CSR_ORDER: order_ff <= csr_wdata[chmsh_pkg::ORDER_W-1:0];
            chmsh_pkg::CSR_SCALE: scale_ff <= csr_wdata[chmsh_pkg::SCALE_W-1:0];
            default:              order_ff <= order_ff;
         endcase
      end
   end

   chmsh_front u_front (
      .cmd   (req_cmd),
      .index (req_index),
      .value (req_value),
      .neg_x (req_neg_x),
      .neg_y (req_neg_y),
      .neg_z (req_neg_z),
      .order (order_ff),
      .n     (n),
      .job   (front_job)
   );

   chmsh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_job),
      .full      (req_full),
      .pop       (job_pop),
      .pop_data  (head_job),
      .empty     (q_empty)
   );

   chmsh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (head_job),
      .job_valid  (!q_empty),
      .job_pop    (job_pop),
      .n          (n),
      .scale      (scale_ff),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .status     (bk_status)
   );

   // the back takes a job only from a non-empty queue
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !q_empty)
      else $error("job popped from empty queue");

   // a job is taken only while the result slot is free
   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> rsp_empty)
      else $error("job taken while a result waits");

   // a result shows up only after a job was taken or work was under way
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(job_pop || bk_status.busy))
      else $error("result appeared without a job");

endmodule
`default_nettype wire

@@ rtl/core/chmsh_front.sv @@
// chmsh_front: classifies an incoming item against the current order
// depends on chmsh_pkg
`default_nettype none
module chmsh_front (
   input  logic [1:0]                        cmd,
   input  logic [chmsh_pkg::INDEX_W-1:0]     index,
   input  logic signed [chmsh_pkg::DATA_W-1:0] value,
   input  logic                              neg_x,
   input  logic                              neg_y,
   input  logic                              neg_z,
   input  logic [chmsh_pkg::ORDER_W-1:0]     order,
   output logic [chmsh_pkg::N_W-1:0]         n,
   output chmsh_pkg::job_type                job
);

   logic [chmsh_pkg::LIM_W-1:0] wt_limit;
   logic [chmsh_pkg::LIM_W-1:0] co_limit;
   logic [chmsh_pkg::LIM_W-1:0] idx_ext;

   always_comb begin
      if (order > chmsh_pkg::ORDER_W'(chmsh_pkg::MAX_ORDER)) begin
         n = chmsh_pkg::N_W'(chmsh_pkg::MAX_ORDER);
      end else begin
         n = chmsh_pkg::N_W'(order);
      end
   end

   assign wt_limit = chmsh_pkg::LIM_W'(2) * chmsh_pkg::LIM_W'(n) * chmsh_pkg::LIM_W'(n);
   assign co_limit = chmsh_pkg::LIM_W'(chmsh_pkg::COMPONENTS) * chmsh_pkg::LIM_W'(n)
                     * chmsh_pkg::LIM_W'(n) * chmsh_pkg::LIM_W'(n);
   assign idx_ext  = chmsh_pkg::LIM_W'(index);

   always_comb begin
      job.cmd    = chmsh_pkg::cmd_type'(cmd);
      job.index  = index;
      job.value  = value;
      job.h      = {!neg_x, !neg_y, !neg_z};
      job.reject = 1'b0;
      job.noop   = 1'b0;
      case (chmsh_pkg::cmd_type'(cmd))
         chmsh_pkg::CMD_LOAD_WEIGHT: job.reject = (idx_ext >= wt_limit);
         chmsh_pkg::CMD_LOAD_CHILD:  job.reject = (idx_ext >= co_limit);
         chmsh_pkg::CMD_READ:        job.reject = (idx_ext >= co_limit);
         chmsh_pkg::CMD_COMPUTE:     job.noop   = (n == '0);
         default:                    job.reject = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/chmsh_queue.sv @@
// chmsh_queue: short job queue between the front and the back
// depends on chmsh_pkg
`default_nettype none
module chmsh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  chmsh_pkg::job_type push_data,
   output logic               full,
   input  logic               pop,
   output chmsh_pkg::job_type pop_data,
   output logic               empty
);

   chmsh_pkg::job_type             entry_ff [chmsh_pkg::QUEUE_DEPTH];
   logic [chmsh_pkg::QP_W-1:0]     wptr_ff, wptr_in;
   logic [chmsh_pkg::QP_W-1:0]     rptr_ff, rptr_in;
   logic [chmsh_pkg::QC_W-1:0]     count_ff, count_in;
   logic                           do_push, do_pop;

   assign full     = (count_ff == chmsh_pkg::QC_W'(chmsh_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + chmsh_pkg::QC_W'(do_push) - chmsh_pkg::QC_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/chmsh_back.sv @@
// chmsh_back: executes jobs, holds the stores and runs the three-pass mac pipeline
// depends on chmsh_pkg
`default_nettype none
module chmsh_back (
   input  logic                                clock,
   input  logic                                reset,
   input  chmsh_pkg::job_type                  job,
   input  logic                                job_valid,
   output logic                                job_pop,
   input  logic [chmsh_pkg::N_W-1:0]           n,
   input  logic [chmsh_pkg::SCALE_W-1:0]       scale,
   output logic signed [chmsh_pkg::DATA_W-1:0] rsp_data,
   output logic                                rsp_status,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output chmsh_pkg::bk_status_type            status
);

   localparam int DW = chmsh_pkg::DATA_W;
   localparam int IW = chmsh_pkg::IDX_W;

   logic signed [DW-1:0] wt_mem     [chmsh_pkg::WT_DEPTH];
   logic signed [DW-1:0] child_mem  [chmsh_pkg::CO_DEPTH];
   logic signed [DW-1:0] a_mem      [chmsh_pkg::CO_DEPTH];
   logic signed [DW-1:0] b_mem      [chmsh_pkg::CO_DEPTH];
   logic signed [DW-1:0] parent_mem [chmsh_pkg::CO_DEPTH];

   logic signed [DW-1:0] wt_rd_ff, child_rd_ff, a_rd_ff, b_rd_ff, parent_rd_ff;

   chmsh_pkg::state_type state_ff, state_in;
   chmsh_pkg::pass_type  pass_ff, pass_in;
   logic [IW-1:0]        i_ff, i_in, j_ff, j_in, k_ff, k_in, q_ff, q_in;
   logic [chmsh_pkg::COMP_W-1:0]  d_ff, d_in;
   logic [chmsh_pkg::DRAIN_W-1:0] drain_ff, drain_in;
   logic [2:0]           h_ff, h_in;

   logic                 res_valid_ff, res_valid_in;
   logic signed [DW-1:0] res_data_ff;
   logic                 res_status_ff;

   logic                 issue, res_set, res_set_status, wt_we, child_we;
   logic signed [DW-1:0] res_set_data;
   logic [chmsh_pkg::CO_AW-1:0] rd_addr, src_addr, dst_addr;
   logic [chmsh_pkg::WT_AW-1:0] wt_raddr;
   logic [IW-1:0]        nm1, csel;
   logic                 hsel, last_q, last_d, last_k, last_j, last_i, last_issue;
   logic                 take;

   chmsh_pkg::pipe_type  ctl1_ff, ctl1_in, ctl2_ff, ctl3_ff, ctl4_ff, ctl4_in, ctl5_ff;
   logic signed [chmsh_pkg::PROD_W-1:0] prod_ff, sp5_ff;
   logic signed [chmsh_pkg::ACC_W-1:0]  acc_ff;
   logic signed [DW-1:0] src_data, v4_ff, v5_ff, wb_data;

   assign nm1    = IW'(n - 1'b1);
   assign last_q = (q_ff == nm1);
   assign last_d = (d_ff == chmsh_pkg::COMP_W'(chmsh_pkg::COMPONENTS - 1));
   assign last_k = (k_ff == nm1);
   assign last_j = (j_ff == nm1);
   assign last_i = (i_ff == nm1);
   assign last_issue = last_q && last_d && last_k && last_j && last_i;
   assign take   = job_valid && !res_valid_ff;

   // address generation: the axis of the current pass is walked by q
   always_comb begin
      case (pass_ff)
         chmsh_pkg::PASS_Z: begin
            src_addr = chmsh_pkg::flat_addr(i_ff, j_ff, q_ff, d_ff, n);
            csel     = k_ff;
            hsel     = h_ff[0];
         end
         chmsh_pkg::PASS_Y: begin
            src_addr = chmsh_pkg::flat_addr(i_ff, q_ff, k_ff, d_ff, n);
            csel     = j_ff;
            hsel     = h_ff[1];
         end
         chmsh_pkg::PASS_X: begin
            src_addr = chmsh_pkg::flat_addr(q_ff, j_ff, k_ff, d_ff, n);
            csel     = i_ff;
            hsel     = h_ff[2];
         end
         default: begin
            src_addr = chmsh_pkg::flat_addr(i_ff, j_ff, q_ff, d_ff, n);
            csel     = k_ff;
            hsel     = h_ff[0];
         end
      endcase
      dst_addr = chmsh_pkg::flat_addr(i_ff, j_ff, k_ff, d_ff, n);
      wt_raddr = chmsh_pkg::WT_AW'(hsel) * chmsh_pkg::WT_AW'(n) * chmsh_pkg::WT_AW'(n)
                 + chmsh_pkg::WT_AW'(csel) * chmsh_pkg::WT_AW'(n) + chmsh_pkg::WT_AW'(q_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chmsh_pkg::ST_IDLE: begin
            if (take) begin
               if (job.cmd == chmsh_pkg::CMD_READ && !job.reject) begin
                  state_in = chmsh_pkg::ST_READ;
               end else if (job.cmd == chmsh_pkg::CMD_COMPUTE && !job.noop) begin
                  state_in = chmsh_pkg::ST_RUN;
               end
            end
         end
         chmsh_pkg::ST_READ:  state_in = chmsh_pkg::ST_IDLE;
         chmsh_pkg::ST_RUN: begin
            if (last_issue) begin
               state_in = chmsh_pkg::ST_DRAIN;
            end
         end
         chmsh_pkg::ST_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = (pass_ff == chmsh_pkg::PASS_X) ? chmsh_pkg::ST_IDLE
                                                          : chmsh_pkg::ST_RUN;
            end
         end
         default: state_in = chmsh_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      job_pop        = 1'b0;
      issue          = 1'b0;
      res_set        = 1'b0;
      res_set_data   = '0;
      res_set_status = 1'b0;
      wt_we          = 1'b0;
      child_we       = 1'b0;
      rd_addr        = src_addr;
      case (state_ff)
         chmsh_pkg::ST_IDLE: begin
            rd_addr = chmsh_pkg::CO_AW'(job.index);
            if (take) begin
               job_pop        = 1'b1;
               res_set_status = job.reject;
               case (job.cmd)
                  chmsh_pkg::CMD_LOAD_WEIGHT: begin
                     wt_we   = !job.reject;
                     res_set = 1'b1;
                  end
                  chmsh_pkg::CMD_LOAD_CHILD: begin
                     child_we = !job.reject;
                     res_set  = 1'b1;
                  end
                  chmsh_pkg::CMD_COMPUTE: res_set = job.noop;
                  chmsh_pkg::CMD_READ:    res_set = job.reject;
                  default:                res_set = 1'b1;
               endcase
            end
         end
         chmsh_pkg::ST_READ: begin
            res_set      = 1'b1;
            res_set_data = parent_rd_ff;
         end
         chmsh_pkg::ST_RUN: issue = 1'b1;
         chmsh_pkg::ST_DRAIN: begin
            res_set = (drain_ff == '0) && (pass_ff == chmsh_pkg::PASS_X);
         end
         default: issue = 1'b0;
      endcase
   end

   // loop counters
   always_comb begin
      pass_in  = pass_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      d_in     = d_ff;
      q_in     = q_ff;
      drain_in = drain_ff;
      h_in     = h_ff;
      case (state_ff)
         chmsh_pkg::ST_IDLE: begin
            pass_in = chmsh_pkg::PASS_Z;
            i_in    = '0;
            j_in    = '0;
            k_in    = '0;
            d_in    = '0;
            q_in    = '0;
            h_in    = job.h;
         end
         chmsh_pkg::ST_RUN: begin
            if (last_issue) begin
               drain_in = chmsh_pkg::DRAIN_W'(chmsh_pkg::DRAIN_CYCLES);
            end
            if (!last_q) begin
               q_in = q_ff + 1'b1;
            end else begin
               q_in = '0;
               if (!last_d) begin
                  d_in = d_ff + 1'b1;
               end else begin
                  d_in = '0;
                  if (!last_k) begin
                     k_in = k_ff + 1'b1;
                  end else begin
                     k_in = '0;
                     if (!last_j) begin
                        j_in = j_ff + 1'b1;
                     end else begin
                        j_in = '0;
                        i_in = last_i ? '0 : i_ff + 1'b1;
                     end
                  end
               end
            end
         end
         chmsh_pkg::ST_DRAIN: begin
            if (drain_ff != '0) begin
               drain_in = drain_ff - 1'b1;
            end else begin
               case (pass_ff)
                  chmsh_pkg::PASS_Z: pass_in = chmsh_pkg::PASS_Y;
                  chmsh_pkg::PASS_Y: pass_in = chmsh_pkg::PASS_X;
                  default:           pass_in = pass_ff;
               endcase
            end
         end
         default: drain_in = drain_ff;
      endcase
   end

   assign res_valid_in = res_set || (res_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chmsh_pkg::ST_IDLE;
         pass_ff      <= chmsh_pkg::PASS_Z;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         d_ff         <= '0;
         q_ff         <= '0;
         drain_ff     <= '0;
         h_ff         <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         d_ff         <= d_in;
         q_ff         <= q_in;
         drain_ff     <= drain_in;
         h_ff         <= h_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_set) begin
         res_data_ff   <= res_set_data;
         res_status_ff <= res_set_status;
      end
   end

   assign rsp_data    = res_data_ff;
   assign rsp_status  = res_status_ff;
   assign rsp_empty   = !res_valid_ff;
   assign status.busy = (state_ff != chmsh_pkg::ST_IDLE);

   // mac pipeline: read, multiply, accumulate, round, scale (x pass only), write back
   always_comb begin
      ctl1_in.valid = issue;
      ctl1_in.first = (q_ff == '0);
      ctl1_in.last  = last_q;
      ctl1_in.pass  = pass_ff;
      ctl1_in.dst   = dst_addr;
      ctl4_in       = ctl3_ff;
      ctl4_in.valid = ctl3_ff.valid && ctl3_ff.last;
      case (ctl1_ff.pass)
         chmsh_pkg::PASS_Z: src_data = child_rd_ff;
         chmsh_pkg::PASS_Y: src_data = a_rd_ff;
         chmsh_pkg::PASS_X: src_data = b_rd_ff;
         default:           src_data = child_rd_ff;
      endcase
      if (ctl5_ff.pass == chmsh_pkg::PASS_X) begin
         wb_data = chmsh_pkg::sat_round30(chmsh_pkg::ACC_W'(sp5_ff));
      end else begin
         wb_data = v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl4_in;
         ctl5_ff <= ctl4_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= src_data * wt_rd_ff;
      if (ctl2_ff.valid) begin
         acc_ff <= (ctl2_ff.first ? '0 : acc_ff) + chmsh_pkg::ACC_W'(prod_ff);
      end
      v4_ff  <= chmsh_pkg::sat_round30(acc_ff);
      sp5_ff <= v4_ff * $signed({1'b0, scale});
      v5_ff  <= v4_ff;
   end

   // stores
   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[chmsh_pkg::WT_AW'(job.index)] <= job.value;
      end
      wt_rd_ff <= wt_mem[wt_raddr];
   end

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[chmsh_pkg::CO_AW'(job.index)] <= job.value;
      end
      child_rd_ff <= child_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl5_ff.valid && ctl5_ff.pass == chmsh_pkg::PASS_Z) begin
         a_mem[ctl5_ff.dst] <= wb_data;
      end
      a_rd_ff <= a_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl5_ff.valid && ctl5_ff.pass == chmsh_pkg::PASS_Y) begin
         b_mem[ctl5_ff.dst] <= wb_data;
      end
      b_rd_ff <= b_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl5_ff.valid && ctl5_ff.pass == chmsh_pkg::PASS_X) begin
         parent_mem[ctl5_ff.dst] <= wb_data;
      end
      parent_rd_ff <= parent_mem[rd_addr];
   end

endmodule
`default_nettype wire
